// ===== rtl/core/mts_pkg.sv =====
`default_nettype none

package mts_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int WORD_BITS   = 32;
   localparam int PTR_BITS    = $clog2(STACK_DEPTH);
   localparam int CNT_BITS    = $clog2(STACK_DEPTH + 1);

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] value;
      logic signed [WORD_BITS-1:0] least;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOAD   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;   // execute the item on the request ports
      logic load;     // refill the top registers from the memory read
      logic publish;  // move the result into the response register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_load; // pop that leaves a new top to fetch
      logic out_free;  // response register can take a result now
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/core/min_tracking_stack_top.sv =====
// Flow: an accepted item goes from the idle state to the finish state, which publishes the
// result into the response register; a pop that exposes an older entry passes through the
// load state first, since the top registers are refilled from the registered read of the
// entry memory. No new item is accepted until the controller is back in idle, and a result
// held back by rsp_ready stalls the next item until it is taken.
// Reset: synchronous; clears the entry count, controller state and response valid.
// The entry memory is not cleared and needs no clearing pass.
`default_nettype none

module min_tracking_stack_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_type,
   input  wire logic signed [mts_pkg::WORD_BITS-1:0] req_push_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [mts_pkg::WORD_BITS-1:0]      rsp_top_value,
   output logic signed [mts_pkg::WORD_BITS-1:0]      rsp_min_value,
   output logic        [mts_pkg::CNT_BITS-1:0]       rsp_occupancy,
   output logic                                      rsp_is_empty,
   output logic                                      rsp_underflow,
   output logic                                      rsp_overflow
);
   import mts_pkg::*;

   cmd_type    cmd;
   status_type status;

   mts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mts_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_type       (req_type),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_top_value  (rsp_top_value),
      .rsp_min_value  (rsp_min_value),
      .rsp_occupancy  (rsp_occupancy),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_underflow  (rsp_underflow),
      .rsp_overflow   (rsp_overflow)
   );

   // a refill only follows a pop that was just executed
   a_load_after_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> $past(cmd.accept) && $past(req_type))
      else $error("top refill without a preceding pop");

   a_occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_occupancy <= CNT_BITS'(STACK_DEPTH)))
      else $error("occupancy beyond stack depth");

   a_empty_reads_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> (rsp_occupancy == '0) && (rsp_top_value == '1)
                                    && (rsp_min_value == '1))
      else $error("empty result does not read as all ones");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_underflow && rsp_overflow))
      else $error("underflow and overflow both set");

   a_min_not_above_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_empty |-> (rsp_min_value <= rsp_top_value))
      else $error("minimum above top value");

endmodule

`default_nettype wire

// ===== rtl/core/mts_ctrl.sv =====
`default_nettype none

module mts_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire mts_pkg::status_type status,
   output mts_pkg::cmd_type         cmd
);
   import mts_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = status.need_load ? ST_LOAD : ST_FINISH;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the response register frees up
            cmd.publish = status.out_free;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/mts_datapath.sv =====
`default_nettype none

module mts_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire mts_pkg::cmd_type                     cmd,
   output mts_pkg::status_type                       status,
   input  wire logic                                 req_type,
   input  wire logic signed [mts_pkg::WORD_BITS-1:0] req_push_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [mts_pkg::WORD_BITS-1:0]      rsp_top_value,
   output logic signed [mts_pkg::WORD_BITS-1:0]      rsp_min_value,
   output logic        [mts_pkg::CNT_BITS-1:0]       rsp_occupancy,
   output logic                                      rsp_is_empty,
   output logic                                      rsp_underflow,
   output logic                                      rsp_overflow
);
   import mts_pkg::*;

   entry_type                   mem [STACK_DEPTH];
   entry_type                   rd_data_ff;
   logic [PTR_BITS-1:0]         rd_addr;

   logic [CNT_BITS-1:0]         count_ff;
   logic [CNT_BITS-1:0]         count_in;
   entry_type                   top_ff;
   entry_type                   top_in;
   logic                        under_ff;
   logic                        under_in;
   logic                        over_ff;
   logic                        over_in;

   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic signed [WORD_BITS-1:0] rsp_top_ff;
   logic signed [WORD_BITS-1:0] rsp_min_ff;
   logic [CNT_BITS-1:0]         rsp_occ_ff;
   logic                        rsp_empty_ff;
   logic                        rsp_under_ff;
   logic                        rsp_over_ff;

   logic                        is_pop;
   logic                        is_empty;
   logic                        is_full;
   logic                        push_ok;
   entry_type                   push_entry;
   logic [CNT_BITS-1:0]         addr_wide;

   assign is_pop   = (req_type == OP_POP);
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CNT_BITS'(STACK_DEPTH));
   assign push_ok  = cmd.accept && !is_pop && !is_full;

   always_comb begin
      push_entry.value = req_push_value;
      push_entry.least = req_push_value;
      if (!is_empty && (top_ff.least < req_push_value)) begin
         push_entry.least = top_ff.least;
      end
   end

   // entry just below the top, fetched while a pop executes
   assign addr_wide = count_ff - CNT_BITS'(2);
   assign rd_addr   = addr_wide[PTR_BITS-1:0];

   assign status.need_load = is_pop && (count_ff > CNT_BITS'(1));
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem[count_ff[PTR_BITS-1:0]] <= push_entry;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      count_in = count_ff;
      top_in   = top_ff;
      under_in = under_ff;
      over_in  = over_ff;
      if (cmd.accept) begin
         under_in = is_pop && is_empty;
         over_in  = !is_pop && is_full;
         if (push_ok) begin
            count_in = count_ff + CNT_BITS'(1);
            top_in   = push_entry;
         end else if (is_pop && !is_empty) begin
            count_in = count_ff - CNT_BITS'(1);
         end
      end else if (cmd.load) begin
         top_in = rd_data_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff   <= top_in;
      under_ff <= under_in;
      over_ff  <= over_in;
      if (cmd.publish) begin
         rsp_top_ff   <= is_empty ? '1 : top_ff.value;
         rsp_min_ff   <= is_empty ? '1 : top_ff.least;
         rsp_occ_ff   <= count_ff;
         rsp_empty_ff <= is_empty;
         rsp_under_ff <= under_ff;
         rsp_over_ff  <= over_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_top_value = rsp_top_ff;
   assign rsp_min_value = rsp_min_ff;
   assign rsp_occupancy = rsp_occ_ff;
   assign rsp_is_empty  = rsp_empty_ff;
   assign rsp_underflow = rsp_under_ff;
   assign rsp_overflow  = rsp_over_ff;

endmodule

`default_nettype wire
